[hw/rtl/postfix_expression_evaluator_defines.svh]
// ----------------------------------------------------------------------------
// Postfix evaluator assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFE_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PFE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/pfe_pkg.sv]
// ----------------------------------------------------------------------------
// Postfix evaluator package
// Token codes, status codes, field widths and the arithmetic unit control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pfe_pkg;

	localparam int unsigned STACK_DEPTH_DEF = 16;
	localparam int unsigned VALUE_WIDTH_DEF = 32;

	localparam int unsigned FUNC_W      = 3;
	localparam int unsigned OPERAND_W   = 32;
	localparam int unsigned TOP_W       = 32;
	localparam int unsigned DEPTH_OUT_W = 5;
	localparam int unsigned STATUS_W    = 2;

	localparam int unsigned MUL_DIGIT = 8;

	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH = 3'd0,
		FN_ADD  = 3'd1,
		FN_SUB  = 3'd2,
		FN_MUL  = 3'd3,
		FN_DIV  = 3'd4,
		FN_POW  = 3'd5
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2,
		ST_DIVZ  = 2'd3
	} status_t;

	typedef struct packed {
		logic  start;
		func_t op;
	} alu_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/pfe_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfe_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/pfe_alu.sv]
// ----------------------------------------------------------------------------
// Postfix evaluator arithmetic unit
// Add and subtract registered straight from the operands; multicycle digit-serial
// multiply, restoring divide and square-and-multiply power, the last three sharing
// one set of work registers.
`timescale 1ns / 1ps
`default_nettype none

module pfe_alu #(
	parameter int unsigned VALUE_WIDTH = pfe_pkg::VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pfe_pkg::alu_ctl_t      ctl,
	input  logic [VALUE_WIDTH-1:0] a,
	input  logic [VALUE_WIDTH-1:0] b,
	output logic                   done,
	output logic [VALUE_WIDTH-1:0] result
);

	import pfe_pkg::*;

	localparam int unsigned CW = $clog2(VALUE_WIDTH);
	localparam int unsigned PW = VALUE_WIDTH + MUL_DIGIT;

	typedef enum logic [2:0] {
		A_IDLE,
		A_MUL,
		A_DIV,
		A_DIVFIX,
		A_POW
	} alu_state_t;

	alu_state_t state_q;
	logic done_q;
	logic [VALUE_WIDTH-1:0] result_q;
	logic [VALUE_WIDTH-1:0] acc_q;
	logic [VALUE_WIDTH-1:0] mcand_q;
	logic [VALUE_WIDTH-1:0] mplier_q;
	logic [VALUE_WIDTH-1:0] pr_q;
	logic [VALUE_WIDTH-1:0] pb_q;
	logic [VALUE_WIDTH-1:0] pe_q;
	logic [CW-1:0] cnt_q;
	logic neg_q;
	logic pow_q;
	logic square_q;

	logic [PW-1:0] prod;
	logic [VALUE_WIDTH-1:0] mul_sum;
	logic [VALUE_WIDTH:0] rem_shift;
	logic [VALUE_WIDTH:0] rem_sub;
	logic rem_ge;
	logic [VALUE_WIDTH-1:0] mag_a;
	logic [VALUE_WIDTH-1:0] mag_b;
	logic [VALUE_WIDTH-1:0] pe_next;

	assign prod      = PW'(mcand_q) * PW'(mplier_q[MUL_DIGIT-1:0]);
	assign mul_sum   = acc_q + prod[VALUE_WIDTH-1:0];
	assign rem_shift = {acc_q, mplier_q[VALUE_WIDTH-1]};
	assign rem_ge    = rem_shift >= {1'b0, mcand_q};
	assign rem_sub   = rem_shift - {1'b0, mcand_q};
	assign mag_a     = a[VALUE_WIDTH-1] ? ('0 - a) : a;
	assign mag_b     = b[VALUE_WIDTH-1] ? ('0 - b) : b;
	assign pe_next   = pe_q >> 1;

	assign done   = done_q;
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			done_q <= 1'b0;
		end else begin
			case (state_q)
				A_IDLE: begin
					if (ctl.start) begin
						case (ctl.op)
							FN_ADD: begin
								result_q <= a + b;
								done_q <= 1'b1;
							end
							FN_SUB: begin
								result_q <= a - b;
								done_q <= 1'b1;
							end
							FN_MUL: begin
								acc_q <= '0;
								mcand_q <= a;
								mplier_q <= b;
								pow_q <= 1'b0;
								done_q <= 1'b0;
								state_q <= A_MUL;
							end
							FN_DIV: begin
								acc_q <= '0;
								mcand_q <= mag_b;
								mplier_q <= mag_a;
								neg_q <= a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1];
								cnt_q <= '0;
								done_q <= 1'b0;
								state_q <= A_DIV;
							end
							FN_POW: begin
								if (b[VALUE_WIDTH-1]) begin
									result_q <= VALUE_WIDTH'(1);
									done_q <= 1'b1;
								end else begin
									pr_q <= VALUE_WIDTH'(1);
									pb_q <= a;
									pe_q <= b;
									pow_q <= 1'b1;
									done_q <= 1'b0;
									state_q <= A_POW;
								end
							end
							default: begin
								result_q <= '0;
								done_q <= 1'b1;
							end
						endcase
					end else begin
						done_q <= 1'b0;
					end
				end
				A_MUL: begin
					if (mplier_q == '0) begin
						if (pow_q) begin
							if (square_q) begin
								pb_q <= acc_q;
							end else begin
								pr_q <= acc_q;
								pe_q <= {pe_q[VALUE_WIDTH-1:1], 1'b0};
							end
							state_q <= A_POW;
						end else begin
							result_q <= acc_q;
							done_q <= 1'b1;
							state_q <= A_IDLE;
						end
					end else begin
						acc_q <= mul_sum;
						mcand_q <= mcand_q << MUL_DIGIT;
						mplier_q <= mplier_q >> MUL_DIGIT;
					end
				end
				A_DIV: begin
					acc_q <= rem_ge ? rem_sub[VALUE_WIDTH-1:0] : rem_shift[VALUE_WIDTH-1:0];
					mplier_q <= {mplier_q[VALUE_WIDTH-2:0], rem_ge};
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(VALUE_WIDTH - 1)) begin
						state_q <= A_DIVFIX;
					end
				end
				A_DIVFIX: begin
					result_q <= neg_q ? ('0 - mplier_q) : mplier_q;
					done_q <= 1'b1;
					state_q <= A_IDLE;
				end
				A_POW: begin
					if (pe_q == '0) begin
						result_q <= pr_q;
						done_q <= 1'b1;
						state_q <= A_IDLE;
					end else if (pe_q[0]) begin
						acc_q <= '0;
						mcand_q <= pr_q;
						mplier_q <= pb_q;
						square_q <= 1'b0;
						state_q <= A_MUL;
					end else begin
						pe_q <= pe_next;
						if (pe_next != '0) begin
							acc_q <= '0;
							mcand_q <= pb_q;
							mplier_q <= pb_q;
							square_q <= 1'b1;
							state_q <= A_MUL;
						end
					end
				end
				default: begin
					done_q <= 1'b0;
					state_q <= A_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[hw/rtl/postfix_expression_evaluator.sv]
// ----------------------------------------------------------------------------
// Postfix expression evaluator
// Evaluates postfix integer expressions one token at a time on a bounded
// value stack, reporting top, depth and a sticky status for every token.
// ----------------------------------------------------------------------------
//  Channel | Handshake             | Fields
//  request | in_valid / in_ready   | func, operand, expr_end
//  result  | out_valid / out_ready | top_value, stack_depth, status, final_valid
//
// A push or a rejected token goes from decode straight to done, a zero divisor by
// way of read; add and subtract also wait on the unit. Multiply takes one 8-bit
// digit per cycle; divide is restoring at one bit per cycle; power reuses the
// multiplier. in_ready is high only idle.
// A new request is taken while a result waits; the one after stalls until it leaves.
// Reset clears the stack pointer and the status; stack entries need no clear.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "postfix_expression_evaluator_defines.svh"

module postfix_expression_evaluator #(
	parameter int unsigned STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF,
	parameter int unsigned VALUE_WIDTH = pfe_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [pfe_pkg::FUNC_W-1:0]           func,
	input  logic signed [pfe_pkg::OPERAND_W-1:0] operand,
	input  logic                                 expr_end,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [pfe_pkg::TOP_W-1:0]     top_value,
	output logic [pfe_pkg::DEPTH_OUT_W-1:0]      stack_depth,
	output logic [pfe_pkg::STATUS_W-1:0]         status,
	output logic                                 final_valid
);

	import pfe_pkg::*;

	localparam int unsigned AW  = $clog2(STACK_DEPTH);
	localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_READ,
		S_WAIT,
		S_DONE
	} state_t;

	state_t state_q;
	logic [SPW-1:0] sp_q;
	status_t err_q;
	func_t func_q;
	logic signed [VALUE_WIDTH-1:0] operand_q;
	logic end_q;
	logic signed [VALUE_WIDTH-1:0] top_q;
	logic out_valid_q;
	logic signed [TOP_W-1:0] top_value_q;
	logic [DEPTH_OUT_W-1:0] stack_depth_q;
	status_t status_q;
	logic final_valid_q;

	logic [SPW-1:0] sp_m2;
	logic ram_we;
	logic [AW-1:0] ram_waddr;
	logic [VALUE_WIDTH-1:0] ram_wdata;
	logic ram_re;
	logic [VALUE_WIDTH-1:0] ram_rdata;
	alu_ctl_t alu_ctl;
	logic alu_done;
	logic [VALUE_WIDTH-1:0] alu_result;
	logic load_out;

	assign sp_m2    = sp_q - SPW'(2);
	assign in_ready = state_q == S_IDLE;
	assign load_out = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = sp_m2[AW-1:0];
		ram_wdata = alu_result;
		if (state_q == S_DECODE && err_q == ST_OK && func_q == FN_PUSH
				&& sp_q < SPW'(STACK_DEPTH)) begin
			ram_we = 1'b1;
			ram_waddr = sp_q[AW-1:0];
			ram_wdata = operand_q;
		end else if (state_q == S_WAIT && alu_done) begin
			ram_we = 1'b1;
		end
	end

	assign ram_re = state_q == S_DECODE;

	assign alu_ctl.start = (state_q == S_READ) && !(func_q == FN_DIV && top_q == '0);
	assign alu_ctl.op    = func_q;

	pfe_ram #(
		.WIDTH(VALUE_WIDTH),
		.DEPTH(STACK_DEPTH)
	) u_stack_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(sp_m2[AW-1:0]),
		.rdata(ram_rdata)
	);

	pfe_alu #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_alu (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (alu_ctl),
		.a     (ram_rdata),
		.b     (top_q),
		.done  (alu_done),
		.result(alu_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sp_q <= '0;
			err_q <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !load_out) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						func_q <= func_t'(func);
						operand_q <= VALUE_WIDTH'(operand);
						end_q <= expr_end;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (err_q == ST_OK) begin
						case (func_q)
							FN_PUSH: begin
								state_q <= S_DONE;
								if (sp_q >= SPW'(STACK_DEPTH)) begin
									err_q <= ST_OVER;
								end else begin
									top_q <= operand_q;
									sp_q <= sp_q + SPW'(1);
								end
							end
							FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_POW: begin
								if (sp_q < SPW'(2)) begin
									err_q <= ST_UNDER;
									state_q <= S_DONE;
								end else begin
									state_q <= S_READ;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end else begin
						state_q <= S_DONE;
					end
				end
				S_READ: begin
					if (alu_ctl.start) begin
						state_q <= S_WAIT;
					end else begin
						err_q <= ST_DIVZ;
						state_q <= S_DONE;
					end
				end
				S_WAIT: begin
					if (alu_done) begin
						top_q <= alu_result;
						sp_q <= sp_q - SPW'(1);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (load_out) begin
						out_valid_q <= 1'b1;
						top_value_q <= (sp_q != '0) ? TOP_W'(top_q) : '0;
						stack_depth_q <= DEPTH_OUT_W'(sp_q);
						status_q <= err_q;
						final_valid_q <= end_q && sp_q == SPW'(1) && err_q == ST_OK;
						if (end_q) begin
							sp_q <= '0;
							err_q <= ST_OK;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign top_value   = top_value_q;
	assign stack_depth = stack_depth_q;
	assign status      = status_q;
	assign final_valid = final_valid_q;

	`PFE_ASSERT_SAME(a_sp_bound, 1'b1, sp_q <= SPW'(STACK_DEPTH), "Stack pointer beyond depth.")
	`PFE_ASSERT_SAME(a_alu_done_wait, alu_done, state_q == S_WAIT, "Unit finished outside wait.")
	`PFE_ASSERT_NEXT(a_err_sticky, state_q == S_DECODE && err_q != ST_OK,
		state_q == S_DONE && $stable(sp_q), "Token changed stack under error.")
	`PFE_ASSERT_SAME(a_final_ok, out_valid && final_valid,
		stack_depth == DEPTH_OUT_W'(1) && status == ST_OK, "Final flag on bad result.")
	`PFE_ASSERT_NEXT(a_one_at_time, in_valid && in_ready, !in_ready,
		"Request taken while busy.")

endmodule

`default_nettype wire

[tb/sv/postfix_expression_evaluator_tb.sv]
// ----------------------------------------------------------------------------
// Postfix expression evaluator testbench
// Drives token requests through the valid/ready input channel, first a short
// table of hand-picked tokens and then random expressions, mostly well formed,
// some overflowing the stack and some random noise. The first table rows are
// checked on given values, the rest on a model of stack, pointer and status.
// The sender runs in bursts with gaps and the receiver stalls on patterns of
// its own, including one long hold-off that backs the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module postfix_expression_evaluator_tb;

	import pfe_pkg::*;

	localparam int unsigned STACK_SLOTS    = STACK_DEPTH_DEF;
	localparam int unsigned RANDOM_TOKENS  = 1250;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned HOLD_CYCLES    = 400;
	localparam int unsigned TAIL_CYCLES    = 500;
	localparam int unsigned MAX_REPORTS    = 10;

	localparam logic [FUNC_W-1:0] FN_SPARE6 = 3'd6;
	localparam logic [FUNC_W-1:0] FN_SPARE7 = 3'd7;

	typedef struct packed {
		logic [TOP_W-1:0]       top;
		logic [DEPTH_OUT_W-1:0] depth;
		logic [STATUS_W-1:0]    st;
		logic                   fin;
	} eval_result_t;

	typedef struct packed {
		logic [FUNC_W-1:0]    fn;
		logic [OPERAND_W-1:0] opnd;
		logic                 last;
		logic                 typed;
		eval_result_t         want;
	} token_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [FUNC_W-1:0]      func = '0;
	logic [OPERAND_W-1:0]   operand = '0;
	logic                   expr_end = 1'b0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [TOP_W-1:0]       top_value;
	logic [DEPTH_OUT_W-1:0] stack_depth;
	logic [STATUS_W-1:0]    status;
	logic                   final_valid;

	token_row_t   token_plan[$];
	eval_result_t pending_results[$];

	logic [OPERAND_W-1:0] calc_stack [STACK_SLOTS];
	int unsigned          calc_sp = 0;
	status_t              calc_err = ST_OK;

	int unsigned mismatch_count = 0;
	int unsigned stall_cycles = 0;
	logic        hold_req = 1'b0;

	postfix_expression_evaluator u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.operand     (operand),
		.expr_end    (expr_end),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.top_value   (top_value),
		.stack_depth (stack_depth),
		.status      (status),
		.final_valid (final_valid)
	);

	initial begin
		forever begin
			#6 clk = ~clk;
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic eval_result_t evaluate_token(input logic [FUNC_W-1:0] fn,
			input logic [OPERAND_W-1:0] opnd, input logic last);
		eval_result_t res;
		logic [OPERAND_W-1:0] x, y, r, b;
		logic [OPERAND_W:0]   mx, my, q;
		logic                 apply;
		if (calc_err == ST_OK && fn <= FN_POW) begin
			if (fn == FN_PUSH) begin
				if (calc_sp >= STACK_SLOTS) begin
					calc_err = ST_OVER;
				end else begin
					calc_stack[calc_sp] = opnd;
					calc_sp++;
				end
			end else if (calc_sp < 2) begin
				calc_err = ST_UNDER;
			end else begin
				x = calc_stack[calc_sp - 2];
				y = calc_stack[calc_sp - 1];
				r = '0;
				apply = 1'b1;
				case (fn)
					FN_ADD: r = x + y;
					FN_SUB: r = x - y;
					FN_MUL: r = x * y;
					FN_DIV: begin
						if (y == '0) begin
							calc_err = ST_DIVZ;
							apply = 1'b0;
						end else begin
							mx = x[OPERAND_W-1] ? ('0 - {1'b1, x}) : {1'b0, x};
							my = y[OPERAND_W-1] ? ('0 - {1'b1, y}) : {1'b0, y};
							q = mx / my;
							if (x[OPERAND_W-1] ^ y[OPERAND_W-1])
								q = '0 - q;
							r = q[OPERAND_W-1:0];
						end
					end
					default: begin
						r = 1;
						if (!y[OPERAND_W-1]) begin
							b = x;
							for (int i = 0; i < OPERAND_W; i++) begin
								if (y[i])
									r = r * b;
								b = b * b;
							end
						end
					end
				endcase
				if (apply) begin
					calc_sp--;
					calc_stack[calc_sp - 1] = r;
				end
			end
		end
		res.top = (calc_sp > 0) ? calc_stack[calc_sp - 1] : '0;
		res.depth = calc_sp[DEPTH_OUT_W-1:0];
		res.st = calc_err;
		res.fin = last && calc_sp == 1 && calc_err == ST_OK;
		if (last) begin
			calc_sp = 0;
			calc_err = ST_OK;
		end
		return res;
	endfunction

	function automatic logic [OPERAND_W-1:0] pick_operand();
		logic [OPERAND_W-1:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: v = $urandom_range(0, 20) - 10;
			5: begin
				case ($urandom_range(0, 4))
					0: v = 32'h8000_0000;
					1: v = 32'h7fff_ffff;
					2: v = 32'hffff_ffff;
					3: v = 32'h0000_0001;
					default: v = '0;
				endcase
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	task automatic plan_token(input logic [FUNC_W-1:0] fn, input logic [OPERAND_W-1:0] opnd,
			input logic last);
		token_row_t row;
		row.fn = fn;
		row.opnd = opnd;
		row.last = last;
		row.typed = 1'b0;
		row.want = '0;
		token_plan.push_back(row);
	endtask

	task automatic plan_known(input logic [FUNC_W-1:0] fn, input logic [OPERAND_W-1:0] opnd,
			input logic last, input logic [TOP_W-1:0] top, input logic [DEPTH_OUT_W-1:0] depth,
			input logic [STATUS_W-1:0] st, input logic fin);
		token_row_t row;
		row.fn = fn;
		row.opnd = opnd;
		row.last = last;
		row.typed = 1'b1;
		row.want.top = top;
		row.want.depth = depth;
		row.want.st = st;
		row.want.fin = fin;
		token_plan.push_back(row);
	endtask

	// The receiver runs in modes of random length; one long hold-off is taken
	// when the sender asks for it.
	always @(posedge clk) begin : receiver
		int unsigned hold_left;
		int unsigned mode_left;
		int unsigned mode;
		int unsigned phase;
		logic        hold_done;
		if (!arst_n) begin
			hold_left = 0;
			mode_left = 0;
			mode = 0;
			phase = 0;
			hold_done = 1'b0;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end else begin
				mode_left--;
			end
			phase++;
			case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= ($urandom_range(0, 3) != 0);
				default: out_ready <= (phase % 8 < 3);
			endcase
		end
	end

	always @(posedge clk) begin : result_check
		eval_result_t want, got;
		if (arst_n && out_valid && out_ready) begin
			got = {top_value, stack_depth, status, final_valid};
			if (pending_results.size() == 0) begin
				if (mismatch_count < MAX_REPORTS)
					$display("unexpected result: top=%h depth=%0d status=%0d final=%0d",
						got.top, got.depth, got.st, got.fin);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					if (mismatch_count < MAX_REPORTS)
						$display("mismatch: expected top=%h depth=%0d status=%0d final=%0d,",
							want.top, want.depth, want.st, want.fin,
							" got top=%h depth=%0d status=%0d final=%0d",
							got.top, got.depth, got.st, got.fin);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin : sender
		token_row_t   row;
		eval_result_t res;
		int unsigned  n_directed, idx, burst_left, gap, n_opnds, pushed, depth, len;
		logic         drain;

		plan_known(FN_ADD,    32'd0,         1'b0, 32'h0000_0000, 5'd0, ST_UNDER, 1'b0);
		plan_known(FN_PUSH,   32'd5,         1'b1, 32'h0000_0000, 5'd0, ST_UNDER, 1'b0);
		plan_known(FN_PUSH,   32'h7fff_ffff, 1'b0, 32'h7fff_ffff, 5'd1, ST_OK,    1'b0);
		plan_known(FN_PUSH,   32'h0000_0001, 1'b0, 32'h0000_0001, 5'd2, ST_OK,    1'b0);
		plan_known(FN_ADD,    32'd0,         1'b0, 32'h8000_0000, 5'd1, ST_OK,    1'b0);
		plan_known(FN_SPARE6, 32'hffff_ffff, 1'b0, 32'h8000_0000, 5'd1, ST_OK,    1'b0);
		plan_known(FN_SPARE7, 32'd0,         1'b1, 32'h8000_0000, 5'd1, ST_OK,    1'b1);
		plan_known(FN_PUSH,   32'h8000_0000, 1'b0, 32'h8000_0000, 5'd1, ST_OK,    1'b0);
		plan_known(FN_PUSH,   32'hffff_ffff, 1'b0, 32'hffff_ffff, 5'd2, ST_OK,    1'b0);
		plan_known(FN_DIV,    32'd0,         1'b0, 32'h8000_0000, 5'd1, ST_OK,    1'b0);
		plan_known(FN_PUSH,   32'd0,         1'b0, 32'h0000_0000, 5'd2, ST_OK,    1'b0);
		plan_known(FN_DIV,    32'd0,         1'b0, 32'h0000_0000, 5'd2, ST_DIVZ,  1'b0);
		plan_known(FN_PUSH,   32'd3,         1'b1, 32'h0000_0000, 5'd2, ST_DIVZ,  1'b0);
		plan_token(FN_PUSH, 32'hffff_fff9, 1'b0);
		plan_token(FN_PUSH, 32'd2,         1'b0);
		plan_token(FN_DIV,  32'd0,         1'b0);
		plan_token(FN_PUSH, 32'd3,         1'b0);
		plan_token(FN_SUB,  32'd0,         1'b0);
		plan_token(FN_PUSH, 32'hffff_fffb, 1'b0);
		plan_token(FN_MUL,  32'd0,         1'b0);
		plan_token(FN_PUSH, 32'hffff_ffff, 1'b0);
		plan_token(FN_POW,  32'd0,         1'b1);
		plan_token(FN_PUSH, 32'hffff_fffd, 1'b0);
		plan_token(FN_PUSH, 32'h7fff_ffff, 1'b0);
		plan_token(FN_POW,  32'd0,         1'b1);
		n_directed = token_plan.size();

		while (token_plan.size() < n_directed + RANDOM_TOKENS) begin
			case ($urandom_range(0, 19))
				0: begin
					len = $urandom_range(STACK_SLOTS + 1, STACK_SLOTS + 3);
					for (int i = 0; i < len; i++)
						plan_token(FN_PUSH, pick_operand(), 1'b0);
					if ($urandom_range(0, 1))
						plan_token(FUNC_W'($urandom_range(FN_ADD, FN_POW)), pick_operand(), 1'b0);
					token_plan[token_plan.size() - 1].last = 1'b1;
				end
				1, 2, 3, 4, 5: begin
					len = $urandom_range(1, 8);
					for (int i = 0; i < len; i++)
						plan_token(FUNC_W'($urandom_range(0, 7)), $urandom,
							($urandom_range(0, 3) == 0));
				end
				default: begin
					n_opnds = ($urandom_range(0, 9) == 0) ? $urandom_range(7, STACK_SLOTS)
						: $urandom_range(1, 5);
					pushed = 0;
					depth = 0;
					while (pushed < n_opnds || depth > 1) begin
						if (pushed < n_opnds && (depth < 2 || $urandom_range(0, 1))) begin
							plan_token(FN_PUSH, pick_operand(), 1'b0);
							pushed++;
							depth++;
						end else begin
							plan_token(FUNC_W'($urandom_range(FN_ADD, FN_POW)), $urandom, 1'b0);
							depth--;
						end
					end
					token_plan[token_plan.size() - 1].last = 1'b1;
				end
			endcase
		end

		do @(posedge clk); while (!arst_n);

		burst_left = 0;
		for (idx = 0; idx < token_plan.size(); idx++) begin
			row = token_plan[idx];
			drain = (idx == n_directed) || (idx == n_directed + 700);
			gap = 0;
			if (!drain && burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			end
			if (burst_left != 0)
				burst_left--;
			if (drain) begin
				in_valid <= 1'b0;
				do @(posedge clk); while (pending_results.size() != 0);
			end else if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			if (idx == n_directed + 60)
				hold_req <= 1'b1;
			in_valid <= 1'b1;
			func <= row.fn;
			operand <= row.opnd;
			expr_end <= row.last;
			do @(posedge clk); while (!in_ready);
			res = evaluate_token(row.fn, row.opnd, row.last);
			pending_results.push_back(row.typed ? row.want : res);
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
